// File: sv/tds_pkg.sv
// Package: types, constants and helpers for the tridiagonal system solver.
`timescale 1ns / 1ps
package tds_pkg;
    localparam int DataW      = 48;
    localparam int FracW      = 24;
    localparam int PivotW     = 25;
    localparam int DefMaxRows = 64;
    localparam int RowW       = 6;
    localparam logic signed [DataW-1:0] PosMax = {1'b0, {(DataW-1){1'b1}}};
    localparam logic signed [DataW-1:0] NegMin = {1'b1, {(DataW-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_MIN_PIVOT = 2'd0
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_C_WAIT,
        ST_PIVOT,
        ST_MUL_D,
        ST_MUL_D_WAIT,
        ST_DIV_C,
        ST_DIV_D,
        ST_STORE,
        ST_BS_READ,
        ST_BS_MUL,
        ST_BS_MUL_WAIT,
        ST_BS_OUT
    } state_t;

    // Saturating 49-bit to 48-bit.
    function automatic logic signed [DataW-1:0] sat49(input logic signed [DataW:0] v);
        logic signed [DataW-1:0] r;
        begin
            if (v > $signed({1'b0, PosMax}))
                r = PosMax;
            else if (v < $signed({1'b1, NegMin}))
                r = NegMin;
            else
                r = v[DataW-1:0];
            return r;
        end
    endfunction

    // Sign and magnitude to saturated 48-bit.
    function automatic logic signed [DataW-1:0] from_mag(input logic neg,
                                                         input logic [DataW:0] m);
        logic signed [DataW-1:0] r;
        begin
            if (neg)
                r = (m >= {2'b01, {(DataW-1){1'b0}}}) ? NegMin
                    : DataW'(-$signed(m));
            else
                r = (m > {2'b00, PosMax}) ? PosMax : DataW'(m);
            return r;
        end
    endfunction
endpackage

// File: sv/tds_mul.sv
// Sequential Q24.24 multiplier: one 24x24 limb product per cycle, rounded and saturated.
`timescale 1ns / 1ps
module tds_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [tds_pkg::DataW-1:0] x,
    input  logic signed [tds_pkg::DataW-1:0] y,
    output logic                        done,
    output logic signed [tds_pkg::DataW-1:0] prod
);
    import tds_pkg::*;

    logic [2:0]      step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            neg_reg, neg_next;
    logic [DataW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [49:0]     acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic [23:0]     opa, opb;
    logic [47:0]     pp;
    logic            done_reg, done_next;
    logic signed [DataW-1:0] prod_reg, prod_next;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin opa = mx_reg[23:0];  opb = my_reg[23:0];  end
            3'd1:    begin opa = mx_reg[47:24]; opb = my_reg[23:0];  end
            3'd2:    begin opa = mx_reg[23:0];  opb = my_reg[47:24]; end
            default: begin opa = mx_reg[47:24]; opb = my_reg[47:24]; end
        endcase
    end
    assign pp = opa * opb;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start)
        begin
            neg_next  = x[DataW-1] ^ y[DataW-1];
            mx_next   = x[DataW-1] ? DataW'(-x) : DataW'(x);
            my_next   = y[DataW-1] ? DataW'(-y) : DataW'(y);
            step_next = 3'd0;
            busy_next = 1'b1;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd0: acc_next = 50'((pp + 48'd8388608) >> 24);
                3'd1, 3'd2: acc_next = acc_reg + 50'(pp);
                3'd3:
                begin
                    if (pp >= 48'd8388608)
                        ovf_next = 1'b1;
                    else
                        acc_next = acc_reg + {pp[25:0], 24'd0};
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (ovf_reg || acc_reg[49:48] != 2'b00)
                        prod_next = from_mag(neg_reg, {1'b1, {DataW{1'b0}}});
                    else
                        prod_next = from_mag(neg_reg, {1'b0, acc_reg[47:0]});
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        ovf_reg  <= ovf_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;
endmodule

// File: sv/tds_div.sv
// Restoring Q24.24 divider: one quotient bit per cycle, rounded and saturated.
`timescale 1ns / 1ps
module tds_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [tds_pkg::DataW-1:0] num,
    input  logic [tds_pkg::DataW-1:0]   den,
    output logic                        done,
    output logic signed [tds_pkg::DataW-1:0] quot
);
    import tds_pkg::*;

    localparam int Bits = DataW + FracW;  // 72 quotient bits
    localparam int CntW = $clog2(Bits + 1);

    logic              busy_reg, busy_next, done_reg, done_next, neg_reg, neg_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [Bits-1:0]   sh_reg, sh_next;     // dividend bits, then quotient
    logic [DataW:0]    rem_reg, rem_next;
    logic [DataW-1:0]  den_reg, den_next;
    logic [DataW:0]    trial;
    logic signed [DataW-1:0] quot_reg, quot_next;
    logic [Bits:0]     qr;

    assign trial = {rem_reg[DataW-1:0], sh_reg[Bits-1]};
    assign qr = {1'b0, sh_reg} + {{Bits{1'b0}}, ({rem_reg[DataW-1:0], 1'b0} >= {1'b0, den_reg})};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            neg_next  = num[DataW-1];
            sh_next   = {(num[DataW-1] ? DataW'(-num) : DataW'(num)), {FracW{1'b0}}};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CntW'(Bits))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (qr[Bits:DataW-1] != '0)
                    quot_next = from_mag(neg_reg, {1'b1, {DataW{1'b0}}});
                else
                    quot_next = from_mag(neg_reg, {1'b0, qr[DataW-1:0]});
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    sh_next  = {sh_reg[Bits-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    sh_next  = {sh_reg[Bits-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// File: sv/tridiagonal_system_solver.sv
// Top level: Thomas-algorithm tridiagonal solver with shared multiplier and divider.
//  channel | dir | fields
//  s_axis  | in  | tdata: sub_diag, main_diag, super_diag, rhs; tlast: last_row
//  m_axis  | out | tdata: solution, row_index, pad; tlast: last_result
//  apb     | in  | reg 0 min_pivot at address 0
// A row needs two products on the shared multiplier and two divisions (72 quotient bits
// each) between accept and the next ready.
// After the last row each further unknown takes one product while the receiver keeps up.
// rst_n clears control state; the row stores need no reset.
// A waiting result holds on m_axis until taken; no new row is accepted meanwhile.
`timescale 1ns / 1ps
module tridiagonal_system_solver #(
    parameter int MAX_ROWS = tds_pkg::DefMaxRows
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // sub_diag, main_diag, super_diag, rhs
    input  logic         s_axis_tlast,   // last_row
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // solution, row_index, zero pad
    output logic         m_axis_tlast,   // last_result
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tds_pkg::*;

    localparam int AddrW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [DataW-1:0] mod_super_mem [MAX_ROWS];
    logic [DataW-1:0] mod_rhs_mem [MAX_ROWS];

    state_t state_reg, state_next;
    logic [PivotW-1:0] min_pivot_reg;
    logic [AddrW-1:0]  row_reg, row_next;
    logic signed [DataW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [DataW-1:0] p_reg, p_next, x_reg, x_next, cn_reg, cn_next;
    logic              last_reg, last_next;
    logic signed [DataW-1:0] cprev_reg, dprev_reg, sup_rd_reg, rhs_rd_reg;
    logic              mul_start, div_start, mul_done, div_done;
    logic signed [DataW-1:0] mul_x, mul_y, mul_p, div_n, div_q;
    logic              wr_en;
    logic signed [DataW-1:0] floor_v, pv;
    logic              ovalid_reg, ovalid_next;
    logic [AddrW-1:0]  rd_addr;

    assign pready = 1'b1;
    assign prdata = 32'(min_pivot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_pivot_reg <= PivotW'(1);
        else if (psel && penable && pwrite && paddr == 2'(REG_MIN_PIVOT))
            min_pivot_reg <= pwdata[PivotW-1:0];
    end

    assign floor_v = (min_pivot_reg == '0) ? DataW'(1) : DataW'(min_pivot_reg);

    tds_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
                   .done(mul_done), .prod(mul_p));
    tds_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n),
                   .den(p_reg), .done(div_done), .quot(div_q));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, RowW'(row_reg), x_reg};
    assign m_axis_tlast  = (row_reg == '0);
    assign wr_en = (state_reg == ST_STORE);
    // previous row's entries stay on cprev/dprev for the whole elimination
    assign rd_addr = row_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mod_super_mem[row_reg] <= cn_reg;
            mod_rhs_mem[row_reg]   <= d_reg;
        end
        cprev_reg  <= mod_super_mem[rd_addr];
        dprev_reg  <= mod_rhs_mem[rd_addr];
        sup_rd_reg <= mod_super_mem[row_reg];
        rhs_rd_reg <= mod_rhs_mem[row_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        p_next = p_reg; x_next = x_reg; cn_next = cn_reg; last_next = last_reg;
        ovalid_next = ovalid_reg;
        mul_start = 1'b0; div_start = 1'b0;
        // row 0 has no previous row
        mul_x = a_reg; mul_y = (row_reg == '0) ? '0 : cprev_reg; div_n = c_reg;
        pv = sat49({b_reg[DataW-1], b_reg} - {mul_p[DataW-1], mul_p});
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    a_next = (row_reg == '0) ? '0 : s_axis_tdata[47:0];
                    b_next = s_axis_tdata[95:48];
                    c_next = s_axis_tdata[143:96];
                    d_next = s_axis_tdata[191:144];
                    last_next = s_axis_tlast || (32'(row_reg) >= MAX_ROWS - 1);
                    if (last_next) c_next = '0;
                    state_next = ST_MUL_C;
                end
            ST_MUL_C:
            begin
                mul_start = 1'b1;
                state_next = ST_MUL_C_WAIT;
            end
            ST_MUL_C_WAIT:
                if (mul_done) state_next = ST_PIVOT;
            ST_PIVOT:
            begin
                p_next = (pv < floor_v) ? floor_v : pv;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                mul_y = (row_reg == '0) ? '0 : dprev_reg;
                mul_start = 1'b1;
                state_next = ST_MUL_D_WAIT;
            end
            ST_MUL_D_WAIT:
                if (mul_done)
                begin
                    d_next = sat49({d_reg[DataW-1], d_reg} - {mul_p[DataW-1], mul_p});
                    div_start = 1'b1;
                    state_next = ST_DIV_C;
                end
            ST_DIV_C:
                if (div_done)
                begin
                    cn_next = div_q;
                    div_n = d_reg;
                    div_start = 1'b1;
                    state_next = ST_DIV_D;
                end
            ST_DIV_D:
                if (div_done)
                begin
                    d_next = div_q;
                    state_next = ST_STORE;
                end
            ST_STORE:
                if (last_reg)
                begin
                    x_next = d_reg;
                    ovalid_next = 1'b1;
                    state_next = ST_BS_OUT;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            ST_BS_OUT:
                if (m_axis_tready)
                begin
                    ovalid_next = 1'b0;
                    if (row_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        row_next = row_reg - 1'b1;
                        state_next = ST_BS_READ;
                    end
                end
            ST_BS_READ:
                state_next = ST_BS_MUL;
            ST_BS_MUL:
            begin
                mul_x = sup_rd_reg;
                mul_y = x_reg;
                mul_start = 1'b1;
                state_next = ST_BS_MUL_WAIT;
            end
            ST_BS_MUL_WAIT:
                if (mul_done)
                begin
                    x_next = sat49({rhs_rd_reg[DataW-1], rhs_rd_reg} - {mul_p[DataW-1], mul_p});
                    ovalid_next = 1'b1;
                    state_next = ST_BS_OUT;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        p_reg <= p_next; x_reg <= x_next; cn_reg <= cn_next; last_reg <= last_next;
    end
endmodule

// File: sv/tds_checker.sv
// Port-level checker for the tridiagonal solver, bound to the top level.
`timescale 1ns / 1ps
module tds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_last_row0: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[53:48] == 6'd0)))
        else $error("last flag mismatch");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");
    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");
endmodule

bind tridiagonal_system_solver tds_checker u_tds_checker (.*);
